// File: hdl/epv_pkg.sv
// Package: shared types and constants of the encoder position/velocity unit.
package epv_pkg;

    localparam int POS_WIDTH      = 32;
    localparam int VEL_WIDTH      = 28;
    localparam int TPS_WIDTH      = 27;
    localparam int TIME_WIDTH_DEF = 32;
    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = 3;

    localparam logic [TPS_WIDTH-1:0] TPS_RESET = 27'd1000000;

    // Register index taken from the word address bit
    localparam logic REG_TPS = 1'b0;

    typedef struct packed {
        logic enc_a;
        logic enc_b;
    } epv_sample_t;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] position;
        logic signed [VEL_WIDTH-1:0] velocity;
        logic                        edge_seen;
    } epv_result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } epv_div_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_PUBLISH
    } epv_state_t;

endpackage

// File: hdl/epv_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module epv_serial_div #(
    parameter int DIVISOR_WIDTH = epv_pkg::TIME_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [epv_pkg::TPS_WIDTH-1:0]       dividend,
    input  logic [DIVISOR_WIDTH-1:0]            divisor,
    output logic [epv_pkg::TPS_WIDTH-1:0]       quotient,
    output epv_pkg::epv_div_stat_t              stat
);

    localparam int QW    = epv_pkg::TPS_WIDTH;
    localparam int CW    = (DIVISOR_WIDTH > QW + 1) ? DIVISOR_WIDTH : QW + 1;
    localparam int CNT_W = $clog2(QW + 1);

    logic [CW-1:0]            rem_reg, rem_next;
    logic [QW-1:0]            quo_reg, quo_next;
    logic [DIVISOR_WIDTH-1:0] div_reg, div_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    logic [CW-1:0] trial;
    logic [CW-1:0] divisor_ext;
    logic [CW-1:0] diff;
    logic          fits;

    // Trial subtract of the shifted partial remainder
    assign trial       = {rem_reg[CW-2:0], quo_reg[QW-1]};
    assign divisor_ext = CW'(div_reg);
    assign fits        = (trial >= divisor_ext);
    assign diff        = trial - divisor_ext;

    // Advance one step per cycle, shift quotient bits in behind the dividend
    always_comb
    begin
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            rem_next   = '0;
            quo_next   = dividend;
            div_next   = divisor;
            count_next = CNT_W'(QW);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? diff : trial;
            quo_next   = {quo_reg[QW-2:0], fits};
            count_next = count_reg - 1'b1;
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: hdl/encoder_position_period_velocity_unit.sv
// Top level: x1 quadrature decoder with period-based velocity and APB timebase register.
//
//   channel  dir  handshake                      word
//   sample   in   sample_valid / sample_ready    epv_sample_t {enc_a, enc_b}
//   result   out  result_valid / result_ready    epv_result_t {position, velocity, edge_seen}
//   apb      in   psel, penable, pwrite, pready  ticks_per_second at byte address 0
//
// A sample without a rising edge of A goes from the idle step straight to publish; a sample
// with a rising edge passes through the bit-serial divider first (27 quotient bits, one per cycle).
// Reset (rst_n low) clears position, velocity, tick count and last A level at once;
// ticks_per_second returns to 1000000.
// A stalled result stays in the output register; the next sample is taken meanwhile,
// and the block waits in its publish step only while that register is still full.
module encoder_position_period_velocity_unit #(
    parameter int TIME_WIDTH = epv_pkg::TIME_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  epv_pkg::epv_sample_t                  sample,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output epv_pkg::epv_result_t                  result,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [epv_pkg::APB_ADDR_WIDTH-1:0]    paddr,
    input  logic [epv_pkg::APB_DATA_WIDTH-1:0]    pwdata,
    output logic [epv_pkg::APB_DATA_WIDTH-1:0]    prdata,
    output logic                                  pready
);

    localparam int PW = epv_pkg::POS_WIDTH;
    localparam int VW = epv_pkg::VEL_WIDTH;
    localparam int TW = epv_pkg::TPS_WIDTH;

    epv_pkg::epv_state_t state_reg, state_next;

    logic [TW-1:0]         tps_reg;
    logic                  last_a_reg;
    logic [PW-1:0]         pos_reg;
    logic [VW-1:0]         speed_reg;
    logic [TIME_WIDTH-1:0] ticks_reg;
    logic                  dir_reg;
    logic                  edge_reg;
    logic                  out_valid_reg;
    epv_pkg::epv_result_t  out_reg;

    logic                  accept;
    logic                  edge_now;
    logic                  cfg_write;
    logic [TIME_WIDTH-1:0] ticks_inc;
    logic                  div_start;
    logic                  publish;
    logic [TW-1:0]         quotient;
    logic [VW-1:0]         mag_ext;
    epv_pkg::epv_div_stat_t div_stat;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        case (paddr[2])
            epv_pkg::REG_TPS: prdata = epv_pkg::APB_DATA_WIDTH'(tps_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tps_reg <= epv_pkg::TPS_RESET;
        else if (cfg_write && paddr[2] == epv_pkg::REG_TPS)
            tps_reg <= pwdata[TW-1:0];
    end

    // Edge detect and saturating tick count
    assign accept    = sample_valid && sample_ready;
    assign edge_now  = sample.enc_a && !last_a_reg;
    assign ticks_inc = (ticks_reg == '1) ? ticks_reg : ticks_reg + 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            epv_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = edge_now ? epv_pkg::ST_DIVIDE : epv_pkg::ST_PUBLISH;
            end
            epv_pkg::ST_DIVIDE:
            begin
                if (div_stat.done)
                    state_next = epv_pkg::ST_PUBLISH;
            end
            epv_pkg::ST_PUBLISH:
            begin
                if (!out_valid_reg || result_ready)
                    state_next = epv_pkg::ST_IDLE;
            end
            default: state_next = epv_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        sample_ready = 1'b0;
        div_start    = 1'b0;
        publish      = 1'b0;
        case (state_reg)
            epv_pkg::ST_IDLE:
            begin
                sample_ready = 1'b1;
                div_start    = sample_valid && edge_now;
            end
            epv_pkg::ST_PUBLISH:
            begin
                publish = !out_valid_reg || result_ready;
            end
            default: ;
        endcase
    end

    epv_serial_div #(
        .DIVISOR_WIDTH (TIME_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (tps_reg),
        .divisor  (ticks_inc),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // Signed velocity from the quotient and the step direction
    assign mag_ext = VW'(quotient);

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= epv_pkg::ST_IDLE;
            last_a_reg <= 1'b0;
            pos_reg    <= '0;
            speed_reg  <= '0;
            ticks_reg  <= '0;
            dir_reg    <= 1'b0;
            edge_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                last_a_reg <= sample.enc_a;
                edge_reg   <= edge_now;
                if (edge_now)
                begin
                    ticks_reg <= '0;
                    dir_reg   <= sample.enc_b;
                    pos_reg   <= sample.enc_b ? pos_reg + 1'b1 : pos_reg - 1'b1;
                end
                else
                    ticks_reg <= ticks_inc;
            end
            if (div_stat.done)
                speed_reg <= dir_reg ? mag_ext : VW'(0) - mag_ext;
        end
    end

    // Output register: hold the word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (publish)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (publish)
        begin
            out_reg.position  <= pos_reg;
            out_reg.velocity  <= speed_reg;
            out_reg.edge_seen <= edge_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTH
    a_busy_only_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> state_reg == epv_pkg::ST_DIVIDE)
        else $error("divider busy outside divide state");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sample_ready |-> !div_stat.busy)
        else $error("sample ready while divider busy");

    a_plain_sample_publishes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !edge_now) |=> state_reg == epv_pkg::ST_PUBLISH)
        else $error("sample without edge did not go to publish");

    a_edge_starts_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && edge_now) |=> div_stat.busy)
        else $error("edge sample did not start divider");
`endif

endmodule

// File: verif/encoder_position_period_velocity_unit_tb.sv
// Testbench for encoder_position_period_velocity_unit: encoder samples in, readings checked.
module encoder_position_period_velocity_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [epv_pkg::APB_ADDR_WIDTH-1:0] ADDR_TPS   = {epv_pkg::REG_TPS, 2'b00};
    localparam logic [epv_pkg::APB_ADDR_WIDTH-1:0] ADDR_SPARE = {~epv_pkg::REG_TPS, 2'b00};
    localparam logic [epv_pkg::TPS_WIDTH-1:0]      TPS_MAX    = '1;
    localparam int                                 SETTLE     = 40;

    // Tracks encoder state and holds the readings the block owes us
    class encoder_scoreboard;
        bit [epv_pkg::TPS_WIDTH-1:0]  rate;
        bit                           last_a;
        bit [epv_pkg::POS_WIDTH-1:0]  count;
        bit [31:0]                    ticks;
        bit [epv_pkg::VEL_WIDTH-1:0]  speed;
        epv_pkg::epv_result_t         expected_readings[$];
        int                           errors;

        function new();
            rate   = epv_pkg::TPS_RESET;
            last_a = 1'b0;
            count  = '0;
            ticks  = '0;
            speed  = '0;
            errors = 0;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        // Count a failure; stay quiet once the log is long enough
        function bit flag();
            errors++;
            return errors <= 100;
        endfunction

        // Advance one timebase tick and queue the reading it produces
        function void note_sample(epv_pkg::epv_sample_t s);
            epv_pkg::epv_result_t reading;
            bit                   rise;
            bit [31:0]            mag;
            rise = s.enc_a && !last_a;
            if (ticks != '1)
                ticks++;
            if (rise)
            begin
                mag = rate / ticks;
                if (s.enc_b)
                begin
                    count = count + 1;
                    speed = mag[epv_pkg::VEL_WIDTH-1:0];
                end
                else
                begin
                    count = count - 1;
                    speed = -mag[epv_pkg::VEL_WIDTH-1:0];
                end
                ticks = '0;
            end
            last_a = s.enc_a;
            reading.position  = count;
            reading.velocity  = speed;
            reading.edge_seen = rise;
            expected_readings.push_back(reading);
        endfunction

        // Compare one delivered word against the oldest reading
        function void check_result(epv_pkg::epv_result_t got);
            epv_pkg::epv_result_t want;
            if (expected_readings.size() == 0)
            begin
                if (flag())
                    $display("%0t: unexpected result word %h", $time, got);
                return;
            end
            want = expected_readings.pop_front();
            if (got.position !== want.position)
                if (flag())
                    $display("%0t: position expected %0d actual %0d",
                             $time, want.position, got.position);
            if (got.velocity !== want.velocity)
                if (flag())
                    $display("%0t: velocity expected %0d actual %0d",
                             $time, want.velocity, got.velocity);
            if (got.edge_seen !== want.edge_seen)
                if (flag())
                    $display("%0t: edge_seen expected %b actual %b",
                             $time, want.edge_seen, got.edge_seen);
        endfunction
    endclass

    logic                                clk;
    logic                                rst_n;
    logic                                sample_valid;
    logic                                sample_ready;
    epv_pkg::epv_sample_t                sample;
    logic                                result_valid;
    logic                                result_ready;
    epv_pkg::epv_result_t                result;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [epv_pkg::APB_ADDR_WIDTH-1:0]  paddr;
    logic [epv_pkg::APB_DATA_WIDTH-1:0]  pwdata;
    logic [epv_pkg::APB_DATA_WIDTH-1:0]  prdata;
    logic                                pready;

    encoder_scoreboard sb;
    int                sent;
    bit                quiet_send;

    encoder_position_period_velocity_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 100 MHz clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Write one register, then read back the timebase and compare
    task write_register(input logic [epv_pkg::APB_ADDR_WIDTH-1:0] addr,
                        input logic [31:0] data);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ADDR_TPS)
            sb.rate = data[epv_pkg::TPS_WIDTH-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_TPS;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== 32'(sb.rate))
            if (sb.flag())
                $display("%0t: ticks_per_second readback expected %0d actual %0d",
                         $time, sb.rate, readback);
        @(posedge clk);
    endtask

    // Hold off the sender until every reading has arrived, then let the block settle
    task drain();
        sample_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Offer one A/B sample and wait for it to be taken
    task send_ab(input bit a, input bit b);
        epv_pkg::epv_sample_t s;
        int                   gap;
        s.enc_a = a;
        s.enc_b = b;
        gap = quiet_send ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        do
            @(posedge clk);
        while (!sample_ready);
        sb.note_sample(s);
        sent++;
        if (sent % 40 == 0)
            quiet_send = ($urandom_range(0, 3) == 0);
    endtask

    // Quadrature-like waveform: random run lengths on A, B mostly following direction
    task run_waveform(input int n, input int pause_at);
        bit a;
        bit dir;
        bit b;
        int run_left;
        a        = 1'b0;
        dir      = 1'b1;
        run_left = 0;
        for (int i = 0; i < n; i++)
        begin
            if (i == pause_at)
                drain();
            if (run_left == 0)
            begin
                a = !a;
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 200)
                                                       : $urandom_range(1, 8);
                if (a && $urandom_range(0, 9) == 0)
                    dir = !dir;
            end
            run_left--;
            b = ($urandom_range(0, 6) == 0) ? 1'($urandom_range(0, 1)) : dir;
            send_ab(a, b);
        end
    endtask

    // Result side: random stalls with stretches of none
    initial
    begin
        int stall;
        int taken;
        bit quiet_recv;
        result_ready <= 1'b0;
        taken      = 0;
        quiet_recv = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = quiet_recv ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
            sb.check_result(result);
            taken++;
            if (taken % 40 == 0)
                quiet_recv = ($urandom_range(0, 3) == 0);
        end
    end

    // Main sequence
    initial
    begin
        sb         = new();
        sent       = 0;
        quiet_send = 1'b0;
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Largest timebase; A high on the first tick is an edge with a period of one
        write_register(ADDR_TPS, 32'(TPS_MAX));
        send_ab(1'b1, 1'b1);
        send_ab(1'b1, 1'b1);
        send_ab(1'b0, 1'b0);
        send_ab(1'b1, 1'b0);
        send_ab(1'b0, 1'b1);
        send_ab(1'b1, 1'b1);
        send_ab(1'b0, 1'b0);
        send_ab(1'b0, 1'b0);
        send_ab(1'b1, 1'b0);
        send_ab(1'b1, 1'b1);
        drain();

        // Zero timebase forces zero velocity at each edge
        write_register(ADDR_TPS, 32'd0);
        send_ab(1'b0, 1'b1);
        send_ab(1'b1, 1'b1);
        send_ab(1'b0, 1'b0);
        send_ab(1'b1, 1'b0);
        drain();

        // Smallest timebase truncates to zero; unused address must not disturb it
        write_register(ADDR_TPS, 32'd1);
        write_register(ADDR_SPARE, $urandom());
        send_ab(1'b0, 1'b1);
        send_ab(1'b1, 1'b1);
        send_ab(1'b0, 1'b0);
        send_ab(1'b1, 1'b0);
        drain();

        // Random waveforms across several timebases, one mid-phase hold-off
        write_register(ADDR_TPS, 32'(epv_pkg::TPS_RESET));
        run_waveform(290, 150);
        drain();
        write_register(ADDR_TPS, 32'(TPS_MAX));
        run_waveform(290, -1);
        drain();
        write_register(ADDR_TPS, $urandom());
        run_waveform(290, -1);
        drain();
        write_register(ADDR_TPS, $urandom_range(1, 1000));
        run_waveform(290, -1);
        drain();
        write_register(ADDR_TPS, 32'd1);
        run_waveform(290, -1);

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("encoder_position_period_velocity_unit_tb: clean");
        else
            $display("encoder_position_period_velocity_unit_tb: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("encoder_position_period_velocity_unit_tb: errors");
        $finish;
    end

endmodule
